/* src/tcc_pkg.sv */
package tcc_pkg;

  localparam int unsigned SAMPLE_W = 12;
  localparam int unsigned COUNT_W  = 16;
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned FREQ_W   = 16;

  // Frequency scale: crossings * 5000 / ms gives tenths of Hz
  localparam int unsigned SCALE_W = 13;
  localparam logic [SCALE_W-1:0] FREQ_SCALE = 13'd5000;

  // Product of crossing count and scale
  localparam int unsigned PROD_W    = COUNT_W + SCALE_W;
  localparam int unsigned DIV_CNT_W = $clog2(PROD_W);

  localparam logic [SAMPLE_W-1:0] THRESHOLD_RESET = 12'd2047;
  localparam logic [COUNT_W-1:0]  LIMIT_RESET     = 16'd1000;

  // Configuration register map
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_LIMIT = 2'd1;

  // Input function codes
  localparam logic FUNC_SAMPLE = 1'b0;
  localparam logic FUNC_REARM  = 1'b1;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

/* src/threshold_crossing_capture_core.sv */
// Channel  Direction  Handshake            Payload
// in       input      in_valid/in_ready    in_func, in_sample, in_time_ms
// out      output     out_valid/out_ready  out_start_ms, out_finish_ms, out_freq_tenths_hz,
//                                          out_points
// cfg      input      cfg_valid/cfg_ready  cfg_index, cfg_wdata
//
// A sample or re-arm that ends no window leaves the sequencer idle. The sample that ends a window
// passes through the transfer, a multiply step, a divider start step, the one-bit-per-cycle
// divider, a saturate step and a load step; zero elapsed time skips the divider and goes
// straight to the load step. in_ready is low while the sequencer is busy. A result waits
// in the output register without blocking new input; the next window end holds in the load
// step until it is taken. cfg_ready is always high. Reset is synchronous, active low.
module threshold_crossing_capture_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_func,
  input  logic [tcc_pkg::SAMPLE_W-1:0]    in_sample,
  input  logic [tcc_pkg::TIME_W-1:0]      in_time_ms,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [tcc_pkg::TIME_W-1:0]      out_start_ms,
  output logic [tcc_pkg::TIME_W-1:0]      out_finish_ms,
  output logic [tcc_pkg::FREQ_W-1:0]      out_freq_tenths_hz,
  output logic [tcc_pkg::COUNT_W-1:0]     out_points,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [tcc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tcc_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import tcc_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_LOAD
  } state_t;

  state_t              state_r, state_nxt;
  logic [SAMPLE_W-1:0] threshold_r, threshold_nxt;
  logic [COUNT_W-1:0]  limit_r, limit_nxt;
  logic [COUNT_W-1:0]  sample_cnt_r, sample_cnt_nxt;
  logic [SAMPLE_W-1:0] prev_r, prev_nxt;
  logic [COUNT_W-1:0]  cross_cnt_r, cross_cnt_nxt;
  logic [TIME_W-1:0]   win_start_r, win_start_nxt;
  logic                stopped_r, stopped_nxt;

  logic [TIME_W-1:0]   res_finish_r, res_finish_nxt;
  logic [TIME_W-1:0]   elapsed_r, elapsed_nxt;
  logic [PROD_W-1:0]   prod_r, prod_nxt;
  logic [FREQ_W-1:0]   freq_r, freq_nxt;
  logic                div_start_r, div_start_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [TIME_W-1:0]   out_start_r, out_start_nxt;
  logic [TIME_W-1:0]   out_finish_r, out_finish_nxt;
  logic [FREQ_W-1:0]   out_freq_r, out_freq_nxt;
  logic [COUNT_W-1:0]  out_points_r, out_points_nxt;

  logic                in_xfer;
  logic                cfg_xfer;
  logic                out_free;
  logic [COUNT_W-1:0]  cnt_inc;
  logic [PROD_W-1:0]   quotient;
  div_stat_t           div_stat;

  tcc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start_r),
    .dividend (prod_r),
    .divisor  (elapsed_r),
    .stat     (div_stat),
    .quotient (quotient)
  );

  assign in_ready  = (state_r == ST_IDLE);
  assign in_xfer   = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign cfg_xfer  = cfg_valid && cfg_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign cnt_inc   = sample_cnt_r + 1'b1;

  always_comb begin
    state_nxt      = state_r;
    threshold_nxt  = threshold_r;
    limit_nxt      = limit_r;
    sample_cnt_nxt = sample_cnt_r;
    prev_nxt       = prev_r;
    cross_cnt_nxt  = cross_cnt_r;
    win_start_nxt  = win_start_r;
    stopped_nxt    = stopped_r;
    res_finish_nxt = res_finish_r;
    elapsed_nxt    = elapsed_r;
    prod_nxt       = prod_r;
    freq_nxt       = freq_r;
    div_start_nxt  = 1'b0;
    out_valid_nxt  = out_valid_r;
    out_start_nxt  = out_start_r;
    out_finish_nxt = out_finish_r;
    out_freq_nxt   = out_freq_r;
    out_points_nxt = out_points_r;

    if (cfg_xfer) begin
      case (cfg_index)
        REG_THRESHOLD:    threshold_nxt = cfg_wdata[SAMPLE_W-1:0];
        REG_SAMPLE_LIMIT: limit_nxt     = cfg_wdata[COUNT_W-1:0];
        default: ;
      endcase
    end

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          if (in_func == FUNC_REARM) begin
            cross_cnt_nxt  = '0;
            sample_cnt_nxt = '0;
            stopped_nxt    = (limit_r == '0);
          end else if (!stopped_r) begin
            if (limit_r == '0) begin
              stopped_nxt = 1'b1;
            end else begin
              if (sample_cnt_r == '0) begin
                win_start_nxt = in_time_ms;
              end else if (in_sample > threshold_r) begin
                if (prev_r < threshold_r) cross_cnt_nxt = cross_cnt_r + 1'b1;
              end else begin
                if (prev_r > threshold_r) cross_cnt_nxt = cross_cnt_r + 1'b1;
              end
              prev_nxt       = in_sample;
              sample_cnt_nxt = cnt_inc;
              if (cnt_inc == limit_r) begin
                stopped_nxt    = 1'b1;
                res_finish_nxt = in_time_ms;
                elapsed_nxt    = in_time_ms - win_start_nxt;
                state_nxt      = ST_MUL;
              end
            end
          end
        end
      end
      ST_MUL: begin
        prod_nxt = PROD_W'(cross_cnt_r) * PROD_W'(FREQ_SCALE);
        if (elapsed_r == '0) begin
          freq_nxt  = '0;
          state_nxt = ST_LOAD;
        end else begin
          div_start_nxt = 1'b1;
          state_nxt     = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_stat.done) begin
          // saturate the quotient to the output width
          freq_nxt  = (quotient[PROD_W-1:FREQ_W] != '0) ? '1 : quotient[FREQ_W-1:0];
          state_nxt = ST_LOAD;
        end
      end
      ST_LOAD: begin
        // hold until the output register is free
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_start_nxt  = win_start_r;
          out_finish_nxt = res_finish_r;
          out_freq_nxt   = freq_r;
          out_points_nxt = sample_cnt_r;
          state_nxt      = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      threshold_r  <= THRESHOLD_RESET;
      limit_r      <= LIMIT_RESET;
      sample_cnt_r <= '0;
      prev_r       <= '0;
      cross_cnt_r  <= '0;
      win_start_r  <= '0;
      stopped_r    <= 1'b0;
      div_start_r  <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      threshold_r  <= threshold_nxt;
      limit_r      <= limit_nxt;
      sample_cnt_r <= sample_cnt_nxt;
      prev_r       <= prev_nxt;
      cross_cnt_r  <= cross_cnt_nxt;
      win_start_r  <= win_start_nxt;
      stopped_r    <= stopped_nxt;
      div_start_r  <= div_start_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    res_finish_r <= res_finish_nxt;
    elapsed_r    <= elapsed_nxt;
    prod_r       <= prod_nxt;
    freq_r       <= freq_nxt;
    out_start_r  <= out_start_nxt;
    out_finish_r <= out_finish_nxt;
    out_freq_r   <= out_freq_nxt;
    out_points_r <= out_points_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_start_ms       = out_start_r;
  assign out_finish_ms      = out_finish_r;
  assign out_freq_tenths_hz = out_freq_r;
  assign out_points         = out_points_r;

endmodule

/* src/tcc_div.sv */
module tcc_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [tcc_pkg::PROD_W-1:0]    dividend,
  input  logic [tcc_pkg::TIME_W-1:0]    divisor,
  output tcc_pkg::div_stat_t            stat,
  output logic [tcc_pkg::PROD_W-1:0]    quotient
);
  import tcc_pkg::*;

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [TIME_W-1:0]    rem_r, rem_nxt;
  logic [TIME_W-1:0]    dvs_r, dvs_nxt;
  logic [PROD_W-1:0]    q_r, q_nxt;
  logic [TIME_W:0]      trial;
  logic [TIME_W:0]      diff;
  logic                 fits;

  // One quotient bit per cycle, restoring form
  assign trial = {rem_r, q_r[PROD_W-1]};
  assign diff  = trial - {1'b0, dvs_r};
  assign fits  = (trial >= {1'b0, dvs_r});

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    q_nxt    = q_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = DIV_CNT_W'(PROD_W - 1);
      rem_nxt  = '0;
      dvs_nxt  = divisor;
      q_nxt    = dividend;
    end else if (busy_r) begin
      rem_nxt = fits ? diff[TIME_W-1:0] : trial[TIME_W-1:0];
      q_nxt   = {q_r[PROD_W-2:0], fits};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    q_r   <= q_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = q_r;

endmodule

/* tb/tb.sv */
module tb;
  import tcc_pkg::*;

  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned RANDOM_ITEMS = 1800;
  localparam int unsigned IDLE_END     = 1550;
  localparam int SAMPLE_MAX = (1 << SAMPLE_W) - 1;

  // Indexes past the register map; writes there must change nothing
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;

  typedef struct {
    logic [TIME_W-1:0]  start_ms;
    logic [TIME_W-1:0]  finish_ms;
    logic [FREQ_W-1:0]  freq;
    logic [COUNT_W-1:0] points;
  } window_report_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  logic                  in_func;
  logic [SAMPLE_W-1:0]   in_sample;
  logic [TIME_W-1:0]     in_time_ms;
  logic                  out_valid;
  logic                  out_ready;
  logic [TIME_W-1:0]     out_start_ms;
  logic [TIME_W-1:0]     out_finish_ms;
  logic [FREQ_W-1:0]     out_freq_tenths_hz;
  logic [COUNT_W-1:0]    out_points;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  // Capture model state
  logic [SAMPLE_W-1:0] cap_threshold = THRESHOLD_RESET;
  logic [COUNT_W-1:0]  cap_limit     = LIMIT_RESET;
  logic [COUNT_W-1:0]  cap_samples   = '0;
  logic [COUNT_W-1:0]  cap_crossings = '0;
  logic [SAMPLE_W-1:0] cap_prev      = '0;
  logic [TIME_W-1:0]   cap_start     = '0;
  logic                cap_halted    = 1'b0;

  window_report_t pending_reports[$];
  window_report_t head_report;
  int unsigned failures     = 0;
  int unsigned live_items   = 0;
  int unsigned quiet_cycles = 0;
  bit          idle_on      = 1'b1;

  threshold_crossing_capture_core i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_func            (in_func),
    .in_sample          (in_sample),
    .in_time_ms         (in_time_ms),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_start_ms       (out_start_ms),
    .out_finish_ms      (out_finish_ms),
    .out_freq_tenths_hz (out_freq_tenths_hz),
    .out_points         (out_points),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata)
  );

  always #1 clk = ~clk;

  function automatic logic [FREQ_W-1:0] crossing_rate(input logic [COUNT_W-1:0] crossings,
                                                      input logic [TIME_W-1:0] elapsed);
    logic [31:0] quot;
    if (elapsed == '0) return '0;
    quot = (32'(crossings) * 32'(FREQ_SCALE)) / elapsed;
    return (quot > 32'hFFFF) ? 16'hFFFF : quot[FREQ_W-1:0];
  endfunction

  // Advance the capture model by one accepted transfer
  task automatic track_item(input logic func, input logic [SAMPLE_W-1:0] smp,
                            input logic [TIME_W-1:0] stamp);
    window_report_t rpt;
    if (func == FUNC_REARM) begin
      cap_crossings = '0;
      cap_samples   = '0;
      cap_halted    = (cap_limit == '0);
    end else if (!cap_halted) begin
      if (cap_limit == '0) begin
        cap_halted = 1'b1;
      end else begin
        if (cap_samples == '0) begin
          cap_start = stamp;
        end else if (smp > cap_threshold) begin
          if (cap_prev < cap_threshold) cap_crossings = cap_crossings + 1'b1;
        end else if (cap_prev > cap_threshold) begin
          cap_crossings = cap_crossings + 1'b1;
        end
        cap_prev    = smp;
        cap_samples = cap_samples + 1'b1;
        if (cap_samples == cap_limit) begin
          cap_halted    = 1'b1;
          rpt.start_ms  = cap_start;
          rpt.finish_ms = stamp;
          rpt.freq      = crossing_rate(cap_crossings, stamp - cap_start);
          rpt.points    = cap_samples;
          pending_reports.push_back(rpt);
        end
      end
    end
  endtask

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      failures++;
      $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_reports.size() == 0) begin
        failures++;
        $display("%0t: unexpected result start %0d finish %0d freq %0d points %0d", $time,
                 out_start_ms, out_finish_ms, out_freq_tenths_hz, out_points);
      end else begin
        head_report = pending_reports.pop_front();
        check_field("start_ms", head_report.start_ms, out_start_ms);
        check_field("finish_ms", head_report.finish_ms, out_finish_ms);
        check_field("freq_tenths_hz", 32'(head_report.freq), 32'(out_freq_tenths_hz));
        check_field("points", 32'(head_report.points), 32'(out_points));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles++;
    end
  end

  // Receiver back-pressure in random bursts
  initial begin
    out_ready = 1'b1;
    forever begin
      @(negedge clk);
      if (idle_on && rst_n && $urandom_range(0, 15) == 0) begin
        out_ready = 1'b0;
        repeat ($urandom_range(1, 14)) @(negedge clk);
      end
      out_ready = 1'b1;
    end
  end

  // Called at a falling edge; returns at the falling edge after the transfer
  task automatic send_item(input logic func, input logic [SAMPLE_W-1:0] smp,
                           input logic [TIME_W-1:0] stamp);
    if (idle_on && $urandom_range(0, 7) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
    in_valid   = 1'b1;
    in_func    = func;
    in_sample  = smp;
    in_time_ms = stamp;
    do @(posedge clk); while (!in_ready);
    if (!(func == FUNC_SAMPLE && cap_halted)) live_items++;
    track_item(func, smp, stamp);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid = 1'b0;
    while (pending_reports.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    wait_drained();
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_wdata = data;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_THRESHOLD) cap_threshold = data[SAMPLE_W-1:0];
    else if (idx == REG_SAMPLE_LIMIT) cap_limit = data;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic logic [SAMPLE_W-1:0] level_below(input logic [SAMPLE_W-1:0] thr);
    if (thr == '0) return '0;
    return SAMPLE_W'($urandom_range(0, int'(thr) - 1));
  endfunction

  function automatic logic [SAMPLE_W-1:0] level_above(input logic [SAMPLE_W-1:0] thr);
    if (int'(thr) == SAMPLE_MAX) return thr;
    return SAMPLE_W'($urandom_range(int'(thr) + 1, SAMPLE_MAX));
  endfunction

  function automatic logic [SAMPLE_W-1:0] level_near(input logic [SAMPLE_W-1:0] thr);
    int v;
    v = int'(thr) + int'($urandom_range(0, 4)) - 2;
    if (v < 0) v = 0;
    else if (v > SAMPLE_MAX) v = SAMPLE_MAX;
    return v[SAMPLE_W-1:0];
  endfunction

  // Reset values: threshold 2047 decides crossings, limit is above three
  task automatic test_reset_defaults();
    send_item(FUNC_SAMPLE, 12'd2048, 32'd5);
    send_item(FUNC_SAMPLE, 12'd2047, 32'd5);
    send_item(FUNC_SAMPLE, 12'd2048, 32'd6);
    write_reg(REG_SAMPLE_LIMIT, 16'd4);
    send_item(FUNC_SAMPLE, 12'd0, 32'd9);
  endtask

  // Elapsed time taken across the 32-bit timestamp wrap
  task automatic test_time_wrap();
    write_reg(REG_THRESHOLD, 16'd0);
    write_reg(REG_SAMPLE_LIMIT, 16'd3);
    send_item(FUNC_REARM, 12'hFFF, 32'hFFFF_FFFF);
    send_item(FUNC_SAMPLE, 12'd0, 32'hFFFF_FFF0);
    send_item(FUNC_SAMPLE, 12'hFFF, 32'hFFFF_FFF8);
    send_item(FUNC_SAMPLE, 12'd0, 32'h0000_0010);
  endtask

  // Top threshold, one-sample window, unused indexes, sample while stopped
  task automatic test_threshold_top();
    write_reg(REG_THRESHOLD, 16'hFFFF);
    write_reg(REG_SPARE_LO, 16'hFFFF);
    write_reg(REG_SPARE_HI, 16'h0000);
    write_reg(REG_SAMPLE_LIMIT, 16'd1);
    send_item(FUNC_REARM, 12'd0, 32'd0);
    send_item(FUNC_SAMPLE, 12'hFFF, 32'hFFFF_FFFF);
    send_item(FUNC_SAMPLE, 12'd0, 32'd0);
  endtask

  task automatic test_limit_zero();
    write_reg(REG_SAMPLE_LIMIT, 16'd5);
    send_item(FUNC_REARM, 12'd7, 32'd0);
    send_item(FUNC_SAMPLE, 12'd100, 32'd1);
    write_reg(REG_SAMPLE_LIMIT, 16'd0);
    send_item(FUNC_SAMPLE, 12'd200, 32'd2);
    send_item(FUNC_SAMPLE, 12'd300, 32'd3);
    send_item(FUNC_REARM, 12'd0, 32'd4);
    write_reg(REG_SAMPLE_LIMIT, 16'd2);
    send_item(FUNC_SAMPLE, 12'd400, 32'd5);
    send_item(FUNC_REARM, 12'd0, 32'd6);
    send_item(FUNC_SAMPLE, 12'hFFF, 32'd10);
    send_item(FUNC_SAMPLE, 12'd0, 32'd11);
  endtask

  // Fifteen crossings in one millisecond overflow the 16-bit rate
  task automatic test_saturation();
    write_reg(REG_THRESHOLD, 16'd2047);
    write_reg(REG_SAMPLE_LIMIT, 16'd16);
    send_item(FUNC_REARM, SAMPLE_W'($urandom_range(0, SAMPLE_MAX)), $urandom());
    for (int k = 0; k < 16; k++) begin
      send_item(FUNC_SAMPLE, k[0] ? level_above(12'd2047) : level_below(12'd2047),
                (k == 15) ? 32'd1001 : 32'd1000);
    end
  endtask

  // Lower the limit below the count: the window runs on and emits nothing until re-armed
  task automatic test_limit_lowered();
    logic [TIME_W-1:0] stamp;
    bit upper;
    stamp = $urandom();
    upper = 1'b0;
    write_reg(REG_SAMPLE_LIMIT, 16'd20);
    send_item(FUNC_REARM, 12'd0, stamp);
    for (int k = 0; k < 6; k++) begin
      upper = ~upper;
      send_item(FUNC_SAMPLE, upper ? level_above(cap_threshold) : level_below(cap_threshold),
                stamp);
      stamp += $urandom_range(0, 3);
    end
    write_reg(REG_SAMPLE_LIMIT, 16'd5);
    for (int k = 0; k < 10; k++) begin
      upper = ~upper;
      send_item(FUNC_SAMPLE, upper ? level_above(cap_threshold) : level_below(cap_threshold),
                stamp);
      stamp += $urandom_range(0, 3);
    end
    send_item(FUNC_REARM, 12'd0, stamp);
  endtask

  task automatic test_random_windows();
    logic [SAMPLE_W-1:0] thr;
    logic [SAMPLE_W-1:0] smp;
    logic [COUNT_W-1:0]  lim;
    logic [TIME_W-1:0]   stamp;
    int unsigned n;
    int unsigned level_mode;
    int unsigned step_mode;
    bit upper;
    upper = 1'b0;
    while (live_items < RANDOM_ITEMS) begin
      case ($urandom_range(0, 5))
        0:       thr = '0;
        1:       thr = '1;
        default: thr = SAMPLE_W'($urandom_range(0, SAMPLE_MAX));
      endcase
      case ($urandom_range(0, 9))
        0:       lim = '0;
        1:       lim = 16'd1;
        2:       lim = COUNT_W'($urandom_range(40, 120));
        default: lim = COUNT_W'($urandom_range(2, 30));
      endcase
      write_reg(REG_THRESHOLD, {4'($urandom()), thr});
      if ($urandom_range(0, 5) == 0) begin
        write_reg($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI, 16'($urandom()));
      end
      write_reg(REG_SAMPLE_LIMIT, lim);
      send_item(FUNC_REARM, SAMPLE_W'($urandom_range(0, SAMPLE_MAX)), $urandom());
      level_mode = $urandom_range(0, 3);
      step_mode  = $urandom_range(0, 3);
      stamp      = $urandom();
      n          = int'(lim) + $urandom_range(0, 2);
      for (int k = 0; k < n; k++) begin
        // occasional re-arm breaks the window
        if ($urandom_range(0, 40) == 0) begin
          send_item(FUNC_REARM, SAMPLE_W'($urandom_range(0, SAMPLE_MAX)), $urandom());
        end
        upper = ~upper;
        case (level_mode)
          0:       smp = SAMPLE_W'($urandom_range(0, SAMPLE_MAX));
          1:       smp = level_near(cap_threshold);
          2:       smp = upper ? level_above(cap_threshold) : level_below(cap_threshold);
          default: smp = ($urandom_range(0, 1) == 0) ? level_near(cap_threshold)
                                                      : SAMPLE_W'($urandom_range(0, SAMPLE_MAX));
        endcase
        send_item(FUNC_SAMPLE, smp, stamp);
        case (step_mode)
          0:       stamp = stamp;
          1:       stamp += $urandom_range(0, 2);
          2:       stamp += $urandom_range(0, 1000);
          default: stamp = $urandom();
        endcase
      end
      if (live_items > IDLE_END) idle_on = 1'b0;
    end
  endtask

  initial begin
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_func    = FUNC_SAMPLE;
    in_sample  = '0;
    in_time_ms = '0;
    cfg_valid  = 1'b0;
    cfg_index  = REG_THRESHOLD;
    cfg_wdata  = '0;
    repeat (7) @(negedge clk);
    rst_n = 1'b1;

    test_reset_defaults();
    test_time_wrap();
    test_threshold_top();
    test_limit_zero();
    test_saturation();
    test_limit_lowered();
    live_items = 0;
    test_random_windows();
    wait_drained();

    if (failures == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
